/* design/opha_pkg.sv */
package opha_pkg;

    localparam int unsigned POOL_SIZE = 256;
    localparam int unsigned HANDLE_W  = 8;
    localparam int unsigned POOL_CAP  = (POOL_SIZE < (1 << HANDLE_W)) ? POOL_SIZE
                                                                     : (1 << HANDLE_W);
    localparam int unsigned PTR_W     = $clog2(POOL_SIZE);
    localparam int unsigned CNT_W     = $clog2(POOL_CAP + 1);

    typedef enum logic [1:0] {
        MODE_ALLOC   = 2'd0,
        MODE_TRY     = 2'd1,
        MODE_DEALLOC = 2'd2,
        MODE_NONE    = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK            = 2'd0,
        ST_NONE_FREED    = 2'd1,
        ST_NOT_ALLOCATED = 2'd2,
        ST_EXHAUSTED     = 2'd3
    } status_t;

    typedef struct packed {
        logic load;
        logic exec;
    } cmd_t;

    typedef struct packed {
        logic out_stall;
    } stat_t;

endpackage

/* design/opha_ctrl.sv */
module opha_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  opha_pkg::stat_t stat,
    output opha_pkg::cmd_t  cmd
);
    import opha_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.exec   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (!stat.out_stall)
                begin
                    cmd.exec   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* design/opha_dp.sv */
module opha_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  opha_pkg::cmd_t                    cmd,
    output opha_pkg::stat_t                   stat,
    input  logic [1:0]                        mode,
    input  logic [opha_pkg::HANDLE_W-1:0]     handle,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [opha_pkg::HANDLE_W-1:0]     result_handle,
    output logic [1:0]                        status
);
    import opha_pkg::*;

    logic [HANDLE_W-1:0] free_queue [POOL_SIZE];

    logic [1:0]          mode_reg;
    logic [HANDLE_W-1:0] handle_reg;
    logic [HANDLE_W-1:0] rd_data_reg;

    logic [PTR_W-1:0]    free_head_reg;
    logic [PTR_W-1:0]    free_head_next;
    logic [CNT_W-1:0]    free_count_reg;
    logic [CNT_W-1:0]    free_count_next;
    logic [CNT_W-1:0]    fresh_next_reg;
    logic [CNT_W-1:0]    fresh_next_next;
    logic [POOL_CAP-1:0] map_reg;
    logic [POOL_CAP-1:0] map_next;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic [HANDLE_W-1:0] result_handle_reg;
    logic [HANDLE_W-1:0] grant;
    status_t             status_reg;
    status_t             result_status;

    logic                push_en;
    logic [PTR_W-1:0]    push_addr;

    assign stat.out_stall = out_valid_reg && !out_ready;
    assign out_valid      = out_valid_reg;
    assign result_handle  = result_handle_reg;
    assign status         = status_reg;

    always_comb
    begin
        free_head_next  = free_head_reg;
        free_count_next = free_count_reg;
        fresh_next_next = fresh_next_reg;
        map_next        = map_reg;
        grant           = '0;
        result_status   = ST_OK;
        push_en         = 1'b0;
        push_addr       = free_head_reg + free_count_reg[PTR_W-1:0];
        case (mode_reg)
            MODE_ALLOC, MODE_TRY:
            begin
                if (free_count_reg != '0)
                begin
                    grant           = rd_data_reg;
                    free_head_next  = free_head_reg + PTR_W'(1);
                    free_count_next = free_count_reg - CNT_W'(1);
                    map_next[rd_data_reg] = 1'b1;
                end
                else if (mode_reg == MODE_TRY)
                begin
                    result_status = ST_NONE_FREED;
                end
                else if (fresh_next_reg < CNT_W'(POOL_CAP))
                begin
                    grant           = fresh_next_reg[HANDLE_W-1:0];
                    fresh_next_next = fresh_next_reg + CNT_W'(1);
                    map_next[fresh_next_reg[HANDLE_W-1:0]] = 1'b1;
                end
                else
                begin
                    result_status = ST_EXHAUSTED;
                end
            end
            MODE_DEALLOC:
            begin
                if ((CNT_W'(handle_reg) >= CNT_W'(POOL_CAP)) || !map_reg[handle_reg])
                begin
                    result_status = ST_NOT_ALLOCATED;
                end
                else
                begin
                    map_next[handle_reg] = 1'b0;
                    if (free_count_reg < CNT_W'(POOL_CAP))
                    begin
                        push_en         = 1'b1;
                        free_count_next = free_count_reg + CNT_W'(1);
                    end
                end
            end
            default:
            begin
                result_status = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.exec)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg    <= mode;
            handle_reg  <= handle;
            rd_data_reg <= free_queue[free_head_reg];
        end
        if (cmd.exec && push_en)
        begin
            free_queue[push_addr] <= handle_reg;
        end
        if (cmd.exec)
        begin
            result_handle_reg <= grant;
            status_reg        <= result_status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_head_reg  <= '0;
            free_count_reg <= '0;
            fresh_next_reg <= '0;
            map_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cmd.exec)
            begin
                free_head_reg  <= free_head_next;
                free_count_reg <= free_count_next;
                fresh_next_reg <= fresh_next_next;
                map_reg        <= map_next;
            end
        end
    end

    a_exec_not_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |-> !(out_valid_reg && !out_ready))
        else $error("Result written while the output beat is stalled.");

    a_fresh_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fresh_next_reg <= CNT_W'(POOL_CAP))
        else $error("Fresh handle counter beyond pool capacity.");

    a_free_le_issued: assert property (@(posedge clk) disable iff (!rst_n)
        free_count_reg <= fresh_next_reg)
        else $error("Free list holds more handles than were ever issued.");

    a_load_exec_excl: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> !cmd.load)
        else $error("Two requests taken on consecutive cycles.");

endmodule

/* design/object_pool_handle_allocator.sv */
// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_ready   mode[1:0], handle[7:0]
// out      output     out_valid / out_ready result_handle[7:0], status[1:0]
//
// Each request is accepted in the idle state, which also reads the free-list head
// from the queue RAM; the exec state then updates the bitmap, pointers and queue.
// The result beat sits in an output register, so the next request is accepted
// while it waits; only the update cycle waits for the output to drain.
// Reset clears the pointers, the fresh counter and the allocated bitmap at once.
module object_pool_handle_allocator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    mode,
    input  logic [opha_pkg::HANDLE_W-1:0] handle,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [opha_pkg::HANDLE_W-1:0] result_handle,
    output logic [1:0]                    status
);
    import opha_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    opha_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    opha_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .mode          (mode),
        .handle        (handle),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .result_handle (result_handle),
        .status        (status)
    );

endmodule
